### src/kf3_pkg.sv
// kf3_pkg: shared types and constants of the three-axis kalman position filter
// request and result structs for both channels, lane control struct, register codes
// no dependencies
package kf3_pkg;

  localparam logic [31:0] ONE_Q16 = 32'd65536;
  localparam logic [16:0] K_ONE = 17'h10000;
  localparam logic [31:0] Q_RESET = 32'd66;
  localparam logic [31:0] R_RESET = 32'd655;
  localparam int NUM_AXES = 3;

  localparam logic CFG_PROCESS_NOISE = 1'b0;
  localparam logic CFG_MEASURE_NOISE = 1'b1;

  typedef struct packed {
    logic kind;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] est_x;
    logic signed [31:0] est_y;
    logic signed [31:0] est_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } out_t;

  // start pulse and gain handed to every axis lane
  typedef struct packed {
    logic go;
    logic [16:0] k;
  } lane_ctl_t;

endpackage

### src/kf3_div.sv
// kf3_div: bit-serial restoring divider for the filter gain k = p1 * 2^16 / den
// one quotient bit per cycle, 17 bits; uses kf3_pkg
module kf3_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] p1,
  input  logic [32:0] den,
  output logic        done,
  output logic [16:0] k
);

  logic [32:0] rem_r;
  logic [32:0] den_q_r;
  logic [16:0] q_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        lsb_r;
  logic        done_r;

  logic [33:0] trial;
  logic        fits;

  // numerator is p1 followed by 16 zero bits; p1[0] enters on the first step
  assign trial = {rem_r, (cnt_r == 5'd16) ? lsb_r : 1'b0};
  assign fits  = (trial >= {1'b0, den_q_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == 5'd0);
      if (start) begin
        busy_r  <= 1'b1;
        cnt_r   <= 5'd16;
        rem_r   <= {2'b00, p1[31:1]};
        lsb_r   <= p1[0];
        den_q_r <= den;
        q_r     <= 17'd0;
      end else if (busy_r) begin
        rem_r <= fits ? 33'(trial - {1'b0, den_q_r}) : trial[32:0];
        q_r   <= {q_r[15:0], fits};
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - 5'd1;
        end
      end
    end
  end

  assign done = done_r;
  assign k    = q_r;

  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    done && (den_q_r != 33'd0) |-> q_r <= kf3_pkg::K_ONE)
    else $error("gain above one");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done)
    else $error("done held longer than one cycle");

endmodule

### src/kf3_lane.sv
// kf3_lane: one axis of the filter update, e' = sat(e + floor((m - e) * k / 2^16))
// two stages: gain multiply, then shift, add and saturate; uses kf3_pkg
module kf3_lane (
  input  logic                    clk,
  input  logic                    rst_n,
  input  kf3_pkg::lane_ctl_t      ctl,
  input  logic signed [31:0]      meas,
  input  logic signed [31:0]      est,
  output logic                    vld,
  output logic signed [31:0]      new_est,
  output logic signed [31:0]      vel
);

  function automatic logic [31:0] sat36(input logic [35:0] v);
    if (v[35:31] == 5'b00000 || v[35:31] == 5'b11111) begin
      return v[31:0];
    end
    return v[35] ? 32'h8000_0000 : 32'h7fff_ffff;
  endfunction

  function automatic logic [31:0] sat33(input logic [32:0] v);
    if (v[32] == v[31]) begin
      return v[31:0];
    end
    return v[32] ? 32'h8000_0000 : 32'h7fff_ffff;
  endfunction

  logic signed [32:0] diff;
  logic signed [17:0] kmul;
  logic signed [50:0] prod;

  logic               v1_r;
  logic signed [50:0] prod_r;
  logic signed [31:0] est1_r;

  logic signed [34:0] step;
  logic        [35:0] sum;
  logic        [31:0] ne;
  logic        [32:0] dv;

  logic               v2_r;
  logic signed [31:0] ne_r;
  logic signed [31:0] vel_r;

  assign diff = $signed({meas[31], meas}) - $signed({est[31], est});
  assign kmul = $signed({1'b0, ctl.k});
  assign prod = diff * kmul;

  // arithmetic shift of the product gives the floor
  assign step = $signed(prod_r[50:16]);
  assign sum  = {{4{est1_r[31]}}, est1_r} + {step[34], step};
  assign ne   = sat36(sum);
  assign dv   = {ne[31], ne} - {est1_r[31], est1_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= ctl.go;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.go) begin
      prod_r <= prod;
      est1_r <= est;
    end
    if (v1_r) begin
      ne_r  <= $signed(ne);
      vel_r <= $signed(sat33(dv));
    end
  end

  assign vld     = v2_r;
  assign new_est = ne_r;
  assign vel     = vel_r;

endmodule

### src/kalman_filter_3axis_position.sv
// kalman_filter_3axis_position: top level, control sequencer, state and output register
// depends on kf3_pkg, kf3_div and kf3_lane
//
// A measurement request adds the process noise as the request is taken, then forms the
// gain denominator, starts the divider, runs the bit-serial gain divider (one quotient bit
// a cycle) and captures the gain, drives the lane multiplies and the variance update, and
// then passes through the lane saturation, the state write-back and the result hand-off. A
// reset request skips the divider and the lanes and goes straight to the result hand-off.
// One request is in flight at a time and the next is taken from the cycle after the
// result is posted; a finished result waits in the output register while the next
// request is taken. Configuration writes land at once; the user must see that they are
// made while the block is idle, as the block itself does not enforce this.
module kalman_filter_3axis_position (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  kf3_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output kf3_pkg::out_t  out_data,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [31:0]    cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_START,
    ST_DIV,
    ST_LANE,
    ST_WAIT,
    ST_DONE
  } state_t;

  state_t state_r;

  logic [31:0] q_r;
  logic [31:0] r_r;
  logic [31:0] p_r;
  logic signed [31:0] est_r [kf3_pkg::NUM_AXES];
  logic signed [31:0] meas_r [kf3_pkg::NUM_AXES];
  logic [31:0] p1_r;
  logic [32:0] den_r;
  logic [16:0] k_r;
  kf3_pkg::out_t res_r;
  kf3_pkg::out_t out_data_r;
  logic          out_valid_r;

  logic        accept;
  logic [32:0] psum;
  logic [16:0] omk;
  logic [48:0] pprod;
  logic        div_start;
  logic        div_done;
  logic [16:0] div_k;

  kf3_pkg::lane_ctl_t lane_ctl;
  logic               lane_vld [kf3_pkg::NUM_AXES];
  logic signed [31:0] lane_est [kf3_pkg::NUM_AXES];
  logic signed [31:0] lane_vel [kf3_pkg::NUM_AXES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= kf3_pkg::Q_RESET;
      r_r <= kf3_pkg::R_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kf3_pkg::CFG_PROCESS_NOISE: q_r <= cfg_wdata;
        kf3_pkg::CFG_MEASURE_NOISE: r_r <= cfg_wdata;
      endcase
    end
  end

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // p + q saturates at all ones
  assign psum = {1'b0, p_r} + {1'b0, q_r};
  assign omk  = kf3_pkg::K_ONE - k_r;
  assign pprod = omk * p1_r;

  assign div_start    = (state_r == ST_START);
  assign lane_ctl.go  = (state_r == ST_LANE);
  assign lane_ctl.k   = k_r;

  kf3_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .p1    (p1_r),
    .den   (den_r),
    .done  (div_done),
    .k     (div_k)
  );

  for (genvar a = 0; a < kf3_pkg::NUM_AXES; a++) begin : g_lane
    kf3_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (lane_ctl),
      .meas    (meas_r[a]),
      .est     (est_r[a]),
      .vld     (lane_vld[a]),
      .new_est (lane_est[a]),
      .vel     (lane_vel[a])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      p_r         <= kf3_pkg::ONE_Q16;
      for (int a = 0; a < kf3_pkg::NUM_AXES; a++) begin
        est_r[a] <= 32'sd0;
      end
    end else begin
      if (out_valid_r && !out_stall && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            meas_r[0] <= in_data.in_x;
            meas_r[1] <= in_data.in_y;
            meas_r[2] <= in_data.in_z;
            p1_r <= psum[32] ? 32'hffff_ffff : psum[31:0];
            if (in_data.kind) begin
              est_r[0] <= in_data.in_x;
              est_r[1] <= in_data.in_y;
              est_r[2] <= in_data.in_z;
              p_r <= kf3_pkg::ONE_Q16;
              res_r.est_x <= in_data.in_x;
              res_r.est_y <= in_data.in_y;
              res_r.est_z <= in_data.in_z;
              res_r.vel_x <= 32'sd0;
              res_r.vel_y <= 32'sd0;
              res_r.vel_z <= 32'sd0;
              state_r <= ST_DONE;
            end else begin
              state_r <= ST_PREP;
            end
          end
        end
        ST_PREP: begin
          den_r   <= {1'b0, p1_r} + {1'b0, r_r};
          state_r <= ST_START;
        end
        ST_START: begin
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            // zero denominator means zero gain
            k_r     <= (den_r == 33'd0) ? 17'd0 : div_k;
            state_r <= ST_LANE;
          end
        end
        ST_LANE: begin
          p_r     <= pprod[47:16];
          state_r <= ST_WAIT;
        end
        ST_WAIT: begin
          if (lane_vld[0]) begin
            for (int a = 0; a < kf3_pkg::NUM_AXES; a++) begin
              est_r[a] <= lane_est[a];
            end
            res_r.est_x <= lane_est[0];
            res_r.est_y <= lane_est[1];
            res_r.est_z <= lane_est[2];
            res_r.vel_x <= lane_vel[0];
            res_r.vel_y <= lane_vel[1];
            res_r.vel_z <= lane_vel[2];
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_data_r  <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_reset_request: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.kind |=> (p_r == kf3_pkg::ONE_Q16) && (state_r == ST_DONE))
    else $error("reset request did not load variance");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (lane_vld[0] == lane_vld[1]) && (lane_vld[1] == lane_vld[2]))
    else $error("axis lanes out of step");

  a_lane_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    lane_vld[0] |-> state_r == ST_WAIT)
    else $error("lane result outside wait state");

endmodule
